// File: sv/pcse_pkg.sv
// Shared constants, codes and types of the pixel color special effects block.
`timescale 1ns / 1ps

package pcse_pkg;

    // Field widths
    localparam int unsigned COLOR_W   = 15;
    localparam int unsigned CH_W      = 5;
    localparam int unsigned LAYER_W   = 3;
    localparam int unsigned WEIGHT_W  = 5;
    localparam int unsigned MASK_W    = 6;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned ARGB_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 6;

    // Channel and weight limits
    localparam logic [CH_W-1:0]     CH_MAX     = 5'd31;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 5'd16;
    localparam logic [7:0]          ALPHA_BYTE = 8'hFF;

    // Layer code of the object layer
    localparam logic [LAYER_W-1:0] LAYER_OBJ = 3'd4;

    // Effect modes
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DARKEN   = 2'd3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TARGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_TARGET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_AMOUNT   = 3'd5;

    typedef logic [CH_W-1:0]     channel_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

// File: sv/pcse_mix.sv
// One color channel mixer: min(31, (c1*w1 + c2*w2) >> 4).
`timescale 1ns / 1ps

module pcse_mix
    import pcse_pkg::*;
(
    input  channel_t c1,
    input  weight_t  w1,
    input  channel_t c2,
    input  weight_t  w2,
    output channel_t res
);

    // 31 * 16 fits in 9 bits, the sum in 10
    logic [2*CH_W-1:0]   prod1;
    logic [2*CH_W-1:0]   prod2;
    logic [2*CH_W:0]     sum;
    logic [2*CH_W-4:0]   scaled;

    assign prod1  = {{CH_W{1'b0}}, c1} * {{CH_W{1'b0}}, w1};
    assign prod2  = {{CH_W{1'b0}}, c2} * {{CH_W{1'b0}}, w2};
    assign sum    = {1'b0, prod1} + {1'b0, prod2};
    assign scaled = sum[2*CH_W:4];

    // saturate at full intensity
    assign res = (scaled > {{(2*CH_W-3-CH_W){1'b0}}, CH_MAX}) ? CH_MAX : scaled[CH_W-1:0];

endmodule

// File: sv/pixel_color_special_effects_top.sv
// Top level of the pixel color special effects stage: blend, brighten, darken.
`timescale 1ns / 1ps

// Channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-----------------------------------------
// input     | in        | in_valid / in_stall    | top_color, under_color, top_layer,
//           |           |                        | under_layer, top_semi_transparent
// output    | out       | out_valid / out_stall  | out_color, out_argb, effect_applied
// config    | in        | cfg_write              | cfg_index, cfg_data
//
// One pixel enters per clock while in_stall is low; each transfer passes through the
// input register, then the result register. The three channel mixers sit between
// those two registers, so sustained throughput is one pixel per cycle without stalls.
// Reset clears the configuration registers and both valid flags.
// A stalled output holds its result; the input register keeps accepting until it
// is also full behind a held result, then in_stall rises.

module pixel_color_special_effects_top
    import pcse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COLOR_W-1:0]    top_color,
    input  logic [COLOR_W-1:0]    under_color,
    input  logic [LAYER_W-1:0]    top_layer,
    input  logic [LAYER_W-1:0]    under_layer,
    input  logic                  top_semi_transparent,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COLOR_W-1:0]    out_color,
    output logic [ARGB_W-1:0]     out_argb,
    output logic                  effect_applied
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] effect_mode_reg;
    logic [MASK_W-1:0] first_target_mask_reg;
    logic [MASK_W-1:0] second_target_mask_reg;
    weight_t           weight_first_reg;
    weight_t           weight_second_reg;
    weight_t           fade_amount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg        <= MODE_NONE;
            first_target_mask_reg  <= '0;
            second_target_mask_reg <= '0;
            weight_first_reg       <= '0;
            weight_second_reg      <= '0;
            fade_amount_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_EFFECT_MODE:   effect_mode_reg        <= cfg_data[MODE_W-1:0];
                REG_FIRST_TARGET:  first_target_mask_reg  <= cfg_data[MASK_W-1:0];
                REG_SECOND_TARGET: second_target_mask_reg <= cfg_data[MASK_W-1:0];
                REG_WEIGHT_FIRST:  weight_first_reg       <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_SECOND: weight_second_reg      <= cfg_data[WEIGHT_W-1:0];
                REG_FADE_AMOUNT:   fade_amount_reg        <= cfg_data[WEIGHT_W-1:0];
                default:           ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the stage after it can take
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s1_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the pixel pair on each input transfer
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] top_color_reg;
    logic [COLOR_W-1:0] under_color_reg;
    logic [LAYER_W-1:0] top_layer_reg;
    logic [LAYER_W-1:0] under_layer_reg;
    logic               top_semi_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            top_color_reg   <= top_color;
            under_color_reg <= under_color;
            top_layer_reg   <= top_layer;
            under_layer_reg <= under_layer;
            top_semi_reg    <= top_semi_transparent;
        end
    end

    // ------------------------------------------------------------------
    // Effect decision
    // ------------------------------------------------------------------
    logic              alpha_obj;
    logic              top_in_mask;
    logic              under_in_mask;
    logic              first_target;
    logic              second_target;
    logic [MODE_W-1:0] mode;
    logic              apply;

    // layer codes six and seven have no mask bit and are never targets
    assign top_in_mask   = (top_layer_reg < LAYER_W'(MASK_W))
                           && first_target_mask_reg[top_layer_reg];
    assign under_in_mask = (under_layer_reg < LAYER_W'(MASK_W))
                           && second_target_mask_reg[under_layer_reg];

    assign alpha_obj     = (top_layer_reg == LAYER_OBJ) && top_semi_reg;
    assign first_target  = top_in_mask || alpha_obj;
    assign second_target = under_in_mask;

    // a semi-transparent object over a second target always blends
    assign mode  = (alpha_obj && second_target) ? MODE_BLEND : effect_mode_reg;
    assign apply = (mode != MODE_NONE) && first_target
                   && (second_target || (mode != MODE_BLEND));

    // ------------------------------------------------------------------
    // Weight selection
    // ------------------------------------------------------------------
    weight_t  eva;
    weight_t  evb;
    weight_t  evy;
    weight_t  mix_w1;
    weight_t  mix_w2;
    logic     use_second;
    channel_t fade_target;

    assign eva = (weight_first_reg  > WEIGHT_MAX) ? WEIGHT_MAX : weight_first_reg;
    assign evb = (weight_second_reg > WEIGHT_MAX) ? WEIGHT_MAX : weight_second_reg;
    assign evy = (fade_amount_reg   > WEIGHT_MAX) ? WEIGHT_MAX : fade_amount_reg;

    always_comb
    begin
        mix_w1      = WEIGHT_MAX - evy;
        mix_w2      = evy;
        use_second  = 1'b0;
        fade_target = '0;
        case (mode)
            MODE_BLEND:
            begin
                mix_w1     = eva;
                mix_w2     = evb;
                use_second = 1'b1;
            end
            MODE_BRIGHTEN:
            begin
                fade_target = CH_MAX;
            end
            default:
            begin
                // darken mixes toward black; none never reaches the mixers' result
                fade_target = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Channel mixers: red, green, blue
    // ------------------------------------------------------------------
    channel_t c1  [3];
    channel_t c2  [3];
    channel_t mix [3];
    logic [COLOR_W-1:0] result_color;

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_channel
        assign c1[ch] = top_color_reg[ch*CH_W +: CH_W];
        assign c2[ch] = use_second ? under_color_reg[ch*CH_W +: CH_W] : fade_target;

        pcse_mix u_mix
        (
            .c1  (c1[ch]),
            .w1  (mix_w1),
            .c2  (c2[ch]),
            .w2  (mix_w2),
            .res (mix[ch])
        );
    end

    // pass the top pixel through when no effect applies
    assign result_color = apply ? {mix[2], mix[1], mix[0]} : top_color_reg;

    // ------------------------------------------------------------------
    // Result register: load when a result moves out of the input register
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] out_color_reg;
    logic               effect_applied_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            out_color_reg      <= result_color;
            effect_applied_reg <= apply;
        end
    end

    assign out_color      = out_color_reg;
    assign effect_applied = effect_applied_reg;
    // ARGB8888: each 5-bit channel moves to the top of its byte
    assign out_argb = {ALPHA_BYTE,
                       out_color_reg[CH_W-1:0],        3'b000,
                       out_color_reg[2*CH_W-1:CH_W],   3'b000,
                       out_color_reg[3*CH_W-1:2*CH_W], 3'b000};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_ready |=> out_valid_reg)
        else $error("pending pixel did not move into the result register");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("input not stalled with both stages full");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_ready |=> s1_valid_reg && $stable(top_color_reg)
                                       && $stable(under_color_reg))
        else $error("input register lost a pixel while the output was held");

    a_no_effect_none: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (mode == MODE_NONE) |-> !apply)
        else $error("effect applied with no effect mode");

endmodule
